FILE: rtl/core/sbeq_pkg.sv
// Shared types, constants and saturation helpers for the six-band equalizer.
// Used by sbeq_ctrl, sbeq_datapath and six_band_biquad_equalizer_core; no dependencies.
package sbeq_pkg;

	// number of cascaded biquad bands (1 to 8)
	localparam int BANDS = 6;
	localparam int BAND_W = (BANDS > 1) ? $clog2(BANDS) : 1;

	// coefficients per band and their slot codes
	localparam int NUM_SLOTS = 5;
	localparam int SLOT_W = 3;
	localparam logic [SLOT_W-1:0] SLOT_B0 = 3'd0;
	localparam logic [SLOT_W-1:0] SLOT_B1 = 3'd1;
	localparam logic [SLOT_W-1:0] SLOT_B2 = 3'd2;
	localparam logic [SLOT_W-1:0] SLOT_A1 = 3'd3;
	localparam logic [SLOT_W-1:0] SLOT_A2 = 3'd4;

	// steps of the per-band sequence
	localparam int BAND_STEPS = 9;
	localparam int STEP_W = $clog2(BAND_STEPS);

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 31;
	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STEREO = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PREAMP = 2'd2;
	localparam logic [CFG_DATA_W-1:0] PREAMP_RESET = 31'h4000_0000;

	// input action codes
	localparam logic ACTION_FRAME = 1'b0;
	localparam logic ACTION_COEF = 1'b1;

	// saturation limits
	localparam logic signed [63:0] SAT32_MAX = 64'sd2147483647;
	localparam logic signed [63:0] SAT32_MIN = -64'sd2147483648;
	localparam logic signed [16:0] SAT16_MAX = 17'sd32767;
	localparam logic signed [16:0] SAT16_MIN = -17'sd32768;

	// multiplier operand selection
	typedef enum logic [1:0] {
		MS_PRE = 2'd0,  // sample << 15 times preamp gain
		MS_X   = 2'd1,  // coefficient times band input
		MS_YLO = 2'd2,  // coefficient times low half of band output
		MS_YHI = 2'd3   // coefficient times high half of band output
	} mul_sel_t;

	// what to do with the registered product or the band state
	typedef enum logic [3:0] {
		ACC_NONE     = 4'd0,
		ACC_PRE      = 4'd1,  // x = sat32(product >> 30)
		ACC_Y        = 4'd2,  // y = (product >> 30) + d1
		ACC_N1       = 4'd3,  // n1 = (product >> 30) + d2
		ACC_N2       = 4'd4,  // n2 = product >> 30
		ACC_N1_SUB_L = 4'd5,
		ACC_N1_SUB_H = 4'd6,
		ACC_N2_SUB_L = 4'd7,
		ACC_N2_SUB_H = 4'd8,
		ACC_COMMIT   = 4'd9,  // store delays, x = sat32(y)
		ACC_RES      = 4'd10  // channel result = sat16(x >> 15)
	} acc_op_t;

	// command word from controller to datapath
	typedef struct packed {
		logic              capture;
		logic              coef_we;
		logic              ch;
		logic [BAND_W-1:0] band;
		logic [SLOT_W-1:0] slot;
		mul_sel_t          mul_sel;
		acc_op_t           acc_op;
		logic              out_load;
	} sbeq_cmd_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > SAT32_MAX) begin
			r = SAT32_MAX[31:0];
		end else if (v < SAT32_MIN) begin
			r = SAT32_MIN[31:0];
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
		logic signed [15:0] r;
		if (v > SAT16_MAX) begin
			r = SAT16_MAX[15:0];
		end else if (v < SAT16_MIN) begin
			r = SAT16_MIN[15:0];
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/sbeq_ctrl.sv
// Sequencer of the equalizer: handshakes, preamp, per-band steps, result hand-off.
// Depends on sbeq_pkg for the command word and sequence constants.
module sbeq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                action,
	input  logic                out_stall,
	input  logic                cfg_enable,
	input  logic                cfg_stereo,
	output logic                in_stall,
	output logic                out_valid,
	output sbeq_pkg::sbeq_cmd_t cmd
);

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_PRE_MUL = 6'b000010,
		ST_PRE_ACC = 6'b000100,
		ST_BAND    = 6'b001000,
		ST_RES     = 6'b010000,
		ST_OUT     = 6'b100000
	} state_t;

	state_t                        state_q;
	logic [sbeq_pkg::STEP_W-1:0]   step_q;
	logic [sbeq_pkg::BAND_W-1:0]   band_q;
	logic                          ch_q;
	logic                          out_valid_q;
	logic                          in_take;
	logic                          out_free;
	logic                          last_step;
	logic                          last_band;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign in_take   = in_valid && (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign last_step = (step_q == sbeq_pkg::STEP_W'(sbeq_pkg::BAND_STEPS - 1));
	assign last_band = (band_q == sbeq_pkg::BAND_W'(sbeq_pkg::BANDS - 1));

	// command decode
	always_comb begin
		cmd          = '0;
		cmd.ch       = ch_q;
		cmd.band     = band_q;
		cmd.slot     = sbeq_pkg::SLOT_B0;
		cmd.mul_sel  = sbeq_pkg::MS_X;
		cmd.acc_op   = sbeq_pkg::ACC_NONE;
		case (state_q)
			ST_IDLE: begin
				cmd.capture = in_take && (action == sbeq_pkg::ACTION_FRAME);
				cmd.coef_we = in_take && (action == sbeq_pkg::ACTION_COEF);
			end
			ST_PRE_MUL: begin
				cmd.mul_sel = sbeq_pkg::MS_PRE;
			end
			ST_PRE_ACC: begin
				cmd.acc_op = sbeq_pkg::ACC_PRE;
			end
			ST_BAND: begin
				// TDF-II step: multiply issued now, product registered and accumulated in the next step
				case (step_q)
					4'd0: begin
						cmd.slot = sbeq_pkg::SLOT_B0;
					end
					4'd1: begin
						cmd.slot   = sbeq_pkg::SLOT_B1;
						cmd.acc_op = sbeq_pkg::ACC_Y;
					end
					4'd2: begin
						cmd.slot   = sbeq_pkg::SLOT_B2;
						cmd.acc_op = sbeq_pkg::ACC_N1;
					end
					4'd3: begin
						cmd.slot    = sbeq_pkg::SLOT_A1;
						cmd.mul_sel = sbeq_pkg::MS_YLO;
						cmd.acc_op  = sbeq_pkg::ACC_N2;
					end
					4'd4: begin
						cmd.slot    = sbeq_pkg::SLOT_A1;
						cmd.mul_sel = sbeq_pkg::MS_YHI;
						cmd.acc_op  = sbeq_pkg::ACC_N1_SUB_L;
					end
					4'd5: begin
						cmd.slot    = sbeq_pkg::SLOT_A2;
						cmd.mul_sel = sbeq_pkg::MS_YLO;
						cmd.acc_op  = sbeq_pkg::ACC_N1_SUB_H;
					end
					4'd6: begin
						cmd.slot    = sbeq_pkg::SLOT_A2;
						cmd.mul_sel = sbeq_pkg::MS_YHI;
						cmd.acc_op  = sbeq_pkg::ACC_N2_SUB_L;
					end
					4'd7: begin
						cmd.acc_op = sbeq_pkg::ACC_N2_SUB_H;
					end
					4'd8: begin
						cmd.acc_op = sbeq_pkg::ACC_COMMIT;
					end
					default: begin
						cmd.acc_op = sbeq_pkg::ACC_NONE;
					end
				endcase
			end
			ST_RES: begin
				cmd.acc_op = sbeq_pkg::ACC_RES;
			end
			ST_OUT: begin
				cmd.out_load = out_free;
			end
			default: begin
				cmd.acc_op = sbeq_pkg::ACC_NONE;
			end
		endcase
	end

	// sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			band_q  <= '0;
			ch_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_take && (action == sbeq_pkg::ACTION_FRAME)) begin
						ch_q <= 1'b0;
						state_q <= cfg_enable ? ST_PRE_MUL : ST_OUT;
					end
				end
				ST_PRE_MUL: begin
					state_q <= ST_PRE_ACC;
				end
				ST_PRE_ACC: begin
					step_q  <= '0;
					band_q  <= '0;
					state_q <= ST_BAND;
				end
				ST_BAND: begin
					if (last_step) begin
						step_q <= '0;
						if (last_band) begin
							state_q <= ST_RES;
						end else begin
							band_q <= band_q + 1'b1;
						end
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_RES: begin
					if (!ch_q && cfg_stereo) begin
						ch_q    <= 1'b1;
						state_q <= ST_PRE_MUL;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output word held until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

FILE: rtl/core/sbeq_datapath.sv
// Equalizer datapath: coefficient and delay stores, shared 33x33 multiplier,
// TDF-II accumulation and the output register. Depends on sbeq_pkg.
module sbeq_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sbeq_pkg::sbeq_cmd_t                 cmd,
	input  logic                                cfg_enable,
	input  logic                                cfg_stereo,
	input  logic [sbeq_pkg::CFG_DATA_W-1:0]     cfg_preamp,
	input  logic signed [15:0]                  sample_left,
	input  logic signed [15:0]                  sample_right,
	input  logic                                block_end,
	input  logic [2:0]                          band_select,
	input  logic [sbeq_pkg::SLOT_W-1:0]         coef_slot,
	input  logic signed [31:0]                  coef_value,
	output logic signed [15:0]                  out_left,
	output logic signed [15:0]                  out_right,
	output logic                                block_end_out
);

	logic signed [31:0] coef_q [sbeq_pkg::BANDS][sbeq_pkg::NUM_SLOTS];
	logic [63:0]        d1_q   [2][sbeq_pkg::BANDS];
	logic [63:0]        d2_q   [2][sbeq_pkg::BANDS];

	logic signed [15:0] sl_q;
	logic signed [15:0] sr_q;
	logic               be_q;
	logic signed [31:0] x_q;
	logic [63:0]        y_q;
	logic [63:0]        n1_q;
	logic [63:0]        n2_q;
	logic signed [65:0] p_q;
	logic signed [15:0] res_q [2];
	logic signed [15:0] out_left_q;
	logic signed [15:0] out_right_q;
	logic               be_out_q;

	logic [7:0]         band_wide;
	logic               coef_hit;
	logic signed [31:0] coef_rd;
	logic signed [15:0] samp;
	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [63:0] lo_term;
	logic [63:0]        hi_term;

	// coefficient write decode
	assign band_wide = 8'(band_select);
	assign coef_hit  = (band_wide < 8'(sbeq_pkg::BANDS)) &&
		(coef_slot < sbeq_pkg::SLOT_W'(sbeq_pkg::NUM_SLOTS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < sbeq_pkg::BANDS; b++) begin
				for (int s = 0; s < sbeq_pkg::NUM_SLOTS; s++) begin
					coef_q[b][s] <= '0;
				end
			end
		end else if (cmd.coef_we && coef_hit) begin
			coef_q[band_wide[sbeq_pkg::BAND_W-1:0]][coef_slot] <= coef_value;
		end
	end

	// operand selection for the shared multiplier
	assign coef_rd = coef_q[cmd.band][cmd.slot];
	assign samp    = cmd.ch ? sr_q : sl_q;

	always_comb begin
		case (cmd.mul_sel)
			sbeq_pkg::MS_PRE: begin
				mul_a = {{2{samp[15]}}, samp, 15'd0};
				mul_b = {2'b00, cfg_preamp};
			end
			sbeq_pkg::MS_X: begin
				mul_a = {coef_rd[31], coef_rd};
				mul_b = {x_q[31], x_q};
			end
			sbeq_pkg::MS_YLO: begin
				mul_a = {coef_rd[31], coef_rd};
				mul_b = {1'b0, y_q[31:0]};
			end
			sbeq_pkg::MS_YHI: begin
				mul_a = {coef_rd[31], coef_rd};
				mul_b = {y_q[63], y_q[63:32]};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// product register
	always_ff @(posedge clk) begin
		p_q <= mul_a * mul_b;
	end

	// floor(product / 2^30) for a low or 32-bit operand, product * 4 for a high half
	assign lo_term = {{28{p_q[65]}}, p_q[65:30]};
	assign hi_term = {p_q[61:0], 2'b00};

	// input capture and accumulation
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sl_q <= sample_left;
			sr_q <= sample_right;
			be_q <= block_end;
		end
		case (cmd.acc_op)
			sbeq_pkg::ACC_PRE:      x_q  <= sbeq_pkg::sat32(lo_term);
			sbeq_pkg::ACC_Y:        y_q  <= lo_term + d1_q[cmd.ch][cmd.band];
			sbeq_pkg::ACC_N1:       n1_q <= lo_term + d2_q[cmd.ch][cmd.band];
			sbeq_pkg::ACC_N2:       n2_q <= lo_term;
			sbeq_pkg::ACC_N1_SUB_L: n1_q <= n1_q - lo_term;
			sbeq_pkg::ACC_N1_SUB_H: n1_q <= n1_q - hi_term;
			sbeq_pkg::ACC_N2_SUB_L: n2_q <= n2_q - lo_term;
			sbeq_pkg::ACC_N2_SUB_H: n2_q <= n2_q - hi_term;
			sbeq_pkg::ACC_COMMIT:   x_q  <= sbeq_pkg::sat32(y_q);
			sbeq_pkg::ACC_RES:      res_q[cmd.ch] <= sbeq_pkg::sat16(x_q[31:15]);
			default: begin
			end
		endcase
	end

	// delay state, written back at the end of each band
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 2; c++) begin
				for (int b = 0; b < sbeq_pkg::BANDS; b++) begin
					d1_q[c][b] <= '0;
					d2_q[c][b] <= '0;
				end
			end
		end else if (cmd.acc_op == sbeq_pkg::ACC_COMMIT) begin
			d1_q[cmd.ch][cmd.band] <= n1_q;
			d2_q[cmd.ch][cmd.band] <= n2_q;
		end
	end

	// output word: filtered or passed through, right muted in mono
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_left_q <= cfg_enable ? res_q[0] : sl_q;
			if (cfg_stereo) begin
				out_right_q <= cfg_enable ? res_q[1] : sr_q;
			end else begin
				out_right_q <= '0;
			end
			be_out_q <= be_q;
		end
	end

	assign out_left      = out_left_q;
	assign out_right     = out_right_q;
	assign block_end_out = be_out_q;

endmodule

FILE: rtl/core/six_band_biquad_equalizer_core.sv
// Six-band cascaded biquad equalizer (Q30 TDF-II), top level with configuration registers.
// Depends on sbeq_pkg, sbeq_ctrl and sbeq_datapath.

// An input word is either an audio frame or a coefficient write. A coefficient write
// gives no output word. A frame, when enabled, goes through the preamp and the six
// bands on a single shared 33x33 multiplier, once per channel, before it reaches the
// output register; a disabled frame goes straight to it. The next input word can be
// taken in the cycle after that load. The block takes one frame at a time and
// stalls its input until the frame's result sits in the output register; that register
// holds it while the output is stalled, and a new input word is taken meanwhile.
// Coefficients are written only while the block is idle, as coefficient writes come
// through the input handshake; configuration must be written only while the block is
// idle, which the block itself does not enforce. Coefficient and delay state clear at
// reset; configuration resets to disabled, stereo and unity preamp gain.
module six_band_biquad_equalizer_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                action,
	input  logic signed [15:0]                  sample_left,
	input  logic signed [15:0]                  sample_right,
	input  logic                                block_end,
	input  logic [2:0]                          band_select,
	input  logic [2:0]                          coef_slot,
	input  logic signed [31:0]                  coef_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [15:0]                  out_left,
	output logic signed [15:0]                  out_right,
	output logic                                block_end_out,
	input  logic                                cfg_wr_en,
	input  logic [sbeq_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sbeq_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

	logic                            enable_q;
	logic                            stereo_q;
	logic [sbeq_pkg::CFG_DATA_W-1:0] preamp_q;
	sbeq_pkg::sbeq_cmd_t             cmd;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			stereo_q <= 1'b1;
			preamp_q <= sbeq_pkg::PREAMP_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				sbeq_pkg::CFG_ENABLE: enable_q <= cfg_wdata[0];
				sbeq_pkg::CFG_STEREO: stereo_q <= cfg_wdata[0];
				sbeq_pkg::CFG_PREAMP: preamp_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	sbeq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.action     (action),
		.out_stall  (out_stall),
		.cfg_enable (enable_q),
		.cfg_stereo (stereo_q),
		.in_stall   (in_stall),
		.out_valid  (out_valid),
		.cmd        (cmd)
	);

	sbeq_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_enable    (enable_q),
		.cfg_stereo    (stereo_q),
		.cfg_preamp    (preamp_q),
		.sample_left   (sample_left),
		.sample_right  (sample_right),
		.block_end     (block_end),
		.band_select   (band_select),
		.coef_slot     (coef_slot),
		.coef_value    (coef_value),
		.out_left      (out_left),
		.out_right     (out_right),
		.block_end_out (block_end_out)
	);

endmodule
